@@ rtl/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked at every clock edge outside reset.
`define AST_IMP(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");
// Implication whose consequent is checked in the cycle after the antecedent.
`define AST_NEXT(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");
`endif

@@ rtl/fwq_pkg.sv @@
`timescale 1ns / 1ps
package fwq_pkg;
  localparam int THREADS_DEF = 64;
  localparam int RESUME_LIMIT_DEF = 16;

  typedef enum logic [7:0] {
    S_IDLE = 8'b00000001,
    S_W_RD = 8'b00000010,
    S_W_WR = 8'b00000100,
    S_K_RD = 8'b00001000,
    S_K_AD = 8'b00010000,
    S_K_CMP = 8'b00100000,
    S_E_RD = 8'b01000000,
    S_E_OUT = 8'b10000000
  } fwq_state_t;
endpackage

@@ rtl/fwq_ram.sv @@
`timescale 1ns / 1ps
module fwq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ rtl/futex_wait_queue.sv @@
`timescale 1ns / 1ps
// Wait: a reject is answered from idle; else the order list is rewritten from the
// head, shifting each waiter back a place up to the thread's old entry or the tail;
// the thread then stands at the head. Wake: per queued waiter an order list read,
// address read and compare; per reported id, a buffer read and an output.
// One request at a time, taken again in the cycle of the last result; results are
// strobed for one cycle and cannot stall. Synchronous reset empties the queue at once.
`include "assert_macros.svh"
module futex_wait_queue #(
  parameter int THREADS = fwq_pkg::THREADS_DEF,
  parameter int RESUME_LIMIT = fwq_pkg::RESUME_LIMIT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        op,
  input  logic [63:0] wait_address,
  input  logic [5:0]  thread_id,
  input  logic [31:0] current_value,
  input  logic [31:0] expected_value,
  input  logic [6:0]  max_wake,
  output logic        result_valid,
  output logic        wait_accepted,
  output logic        woken_valid,
  output logic [5:0]  woken_thread,
  output logic [6:0]  woken_total,
  output logic        last
);
  import fwq_pkg::*;

  localparam int IW = $clog2(THREADS);
  localparam int CW = $clog2(THREADS + 1);
  localparam int EW = (IW > 6) ? IW : 6;
  localparam int TW = (CW > 7) ? CW : 7;
  localparam int BW = (RESUME_LIMIT > 1) ? $clog2(RESUME_LIMIT) : 1;

  fwq_state_t state;
  logic [CW-1:0] n, k, w, taken, j;
  logic [IW-1:0] carry, tid_q, x_q;
  logic [63:0] addr_q;
  logic [6:0] maxw_q;

  logic [EW-1:0] tid_ext;
  logic [IW-1:0] tid_idx;
  logic wait_ok, accept, pick;
  logic ord_we, buf_we, adr_we;
  logic [IW-1:0] ord_waddr, ord_wdata, ord_rdata, buf_rdata;
  logic [63:0] adr_rdata;
  logic [EW-1:0] buf_ext;
  logic [TW-1:0] taken_ext;

  assign busy = (state != S_IDLE);
  assign accept = start && !busy;
  assign tid_ext = EW'(thread_id);
  assign tid_idx = tid_ext[IW-1:0];
  assign wait_ok = (32'(tid_ext) < 32'(THREADS)) && (current_value == expected_value);
  assign pick = (adr_rdata == addr_q) && (32'(taken) < 32'(maxw_q));
  assign buf_ext = EW'(buf_rdata);
  assign taken_ext = TW'(taken);

  always_comb begin
    ord_we = 1'b0;
    ord_waddr = k[IW-1:0];
    ord_wdata = carry;
    case (state)
      S_W_RD: ord_we = (k == n);
      S_W_WR: ord_we = 1'b1;
      S_K_CMP: begin
        ord_we = !pick;
        ord_waddr = w[IW-1:0];
        ord_wdata = x_q;
      end
      default: ord_we = 1'b0;
    endcase
  end

  assign adr_we = accept && !op && wait_ok;
  assign buf_we = (state == S_K_CMP) && pick && (32'(taken) < 32'(RESUME_LIMIT));

  fwq_ram #(.WIDTH(IW), .DEPTH(THREADS)) u_order (
    .clk(clk), .we(ord_we), .waddr(ord_waddr), .wdata(ord_wdata),
    .raddr(k[IW-1:0]), .rdata(ord_rdata)
  );

  fwq_ram #(.WIDTH(64), .DEPTH(THREADS)) u_addr (
    .clk(clk), .we(adr_we), .waddr(tid_idx), .wdata(wait_address),
    .raddr(ord_rdata), .rdata(adr_rdata)
  );

  fwq_ram #(.WIDTH(IW), .DEPTH(RESUME_LIMIT)) u_resume (
    .clk(clk), .we(buf_we), .waddr(taken[BW-1:0]), .wdata(x_q),
    .raddr(j[BW-1:0]), .rdata(buf_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      n <= '0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            addr_q <= wait_address;
            maxw_q <= max_wake;
            k <= '0;
            w <= '0;
            taken <= '0;
            carry <= tid_idx;
            tid_q <= tid_idx;
            if (op) begin
              state <= S_K_RD;
            end else if (wait_ok) begin
              state <= S_W_RD;
            end else begin
              result_valid <= 1'b1;
              wait_accepted <= 1'b0;
              woken_valid <= 1'b0;
              woken_thread <= '0;
              woken_total <= '0;
              last <= 1'b1;
            end
          end
        end
        S_W_RD: begin
          // Reaching the tail means the thread was not queued yet.
          if (k == n) begin
            n <= n + 1'b1;
            state <= S_IDLE;
            result_valid <= 1'b1;
            wait_accepted <= 1'b1;
            woken_valid <= 1'b0;
            woken_thread <= '0;
            woken_total <= '0;
            last <= 1'b1;
          end else begin
            state <= S_W_WR;
          end
        end
        S_W_WR: begin
          if (ord_rdata == tid_q) begin
            state <= S_IDLE;
            result_valid <= 1'b1;
            wait_accepted <= 1'b1;
            woken_valid <= 1'b0;
            woken_thread <= '0;
            woken_total <= '0;
            last <= 1'b1;
          end else begin
            carry <= ord_rdata;
            k <= k + 1'b1;
            state <= S_W_RD;
          end
        end
        S_K_RD: begin
          if (k == n) begin
            n <= w;
            j <= '0;
            if (taken == '0) begin
              state <= S_IDLE;
              result_valid <= 1'b1;
              wait_accepted <= 1'b0;
              woken_valid <= 1'b0;
              woken_thread <= '0;
              woken_total <= '0;
              last <= 1'b1;
            end else begin
              state <= S_E_RD;
            end
          end else begin
            state <= S_K_AD;
          end
        end
        S_K_AD: begin
          x_q <= ord_rdata;
          state <= S_K_CMP;
        end
        S_K_CMP: begin
          // Waiters that stay are compacted toward the head, keeping age order.
          if (pick) begin
            taken <= taken + 1'b1;
          end else begin
            w <= w + 1'b1;
          end
          k <= k + 1'b1;
          state <= S_K_RD;
        end
        S_E_RD: state <= S_E_OUT;
        S_E_OUT: begin
          result_valid <= 1'b1;
          wait_accepted <= 1'b0;
          woken_valid <= 1'b1;
          woken_thread <= buf_ext[5:0];
          woken_total <= taken_ext[6:0];
          if ((j + 1'b1 == taken) || (32'(j) + 32'd1 == 32'(RESUME_LIMIT))) begin
            last <= 1'b1;
            state <= S_IDLE;
          end else begin
            last <= 1'b0;
            j <= j + 1'b1;
            state <= S_E_RD;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `AST_IMP(a_count_range, clk, rst, 1'b1, 32'(n) <= 32'(THREADS))
  `AST_IMP(a_woken_total, clk, rst, result_valid && woken_valid, woken_total != 7'd0)
  `AST_IMP(a_wait_single, clk, rst, result_valid && wait_accepted, last && !woken_valid)
  `AST_NEXT(a_accept_prog, clk, rst, accept, busy || result_valid)
endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps
module tb_top;
  localparam int THREADS = fwq_pkg::THREADS_DEF;
  localparam int RESUME_LIMIT = fwq_pkg::RESUME_LIMIT_DEF;
  localparam logic OP_WAIT = 1'b0;
  localparam logic OP_WAKE = 1'b1;
  localparam int STALL_LIMIT = 20000;

  typedef struct packed {
    logic        op;
    logic [63:0] addr;
    logic [5:0]  tid;
    logic [31:0] cur;
    logic [31:0] expv;
    logic [6:0]  maxw;
  } fx_req_t;

  typedef struct packed {
    logic       acc;
    logic       valid;
    logic [5:0] tid;
    logic [6:0] total;
    logic       last;
  } fx_res_t;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic        op;
  logic [63:0] wait_address;
  logic [5:0]  thread_id;
  logic [31:0] current_value;
  logic [31:0] expected_value;
  logic [6:0]  max_wake;
  logic        result_valid;
  logic        wait_accepted;
  logic        woken_valid;
  logic [5:0]  woken_thread;
  logic [6:0]  woken_total;
  logic        last;

  futex_wait_queue dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .op(op),
    .wait_address(wait_address), .thread_id(thread_id),
    .current_value(current_value), .expected_value(expected_value),
    .max_wake(max_wake), .result_valid(result_valid),
    .wait_accepted(wait_accepted), .woken_valid(woken_valid),
    .woken_thread(woken_thread), .woken_total(woken_total), .last(last)
  );

  // Shadow copy of the wait queue.
  logic        q_waiting [THREADS];
  logic [63:0] q_addr [THREADS];
  int          q_rank [THREADS];

  fx_req_t pending_reqs[$];
  fx_res_t expected_results[$];
  int      mismatches;
  int      send_idle_pct;
  bit      hold_send;
  int      quiet_cycles;

  function automatic fx_res_t mk_res(logic a, logic v, logic [5:0] t, logic [6:0] n,
                                     logic l);
    fx_res_t r;
    r.acc = a; r.valid = v; r.tid = t; r.total = n; r.last = l;
    return r;
  endfunction

  task automatic predict_queue(input fx_req_t rq);
    int ordered [THREADS];
    int picked [THREADS];
    int newrank [THREADS];
    int lim, taken, nres, old, r;
    bit ok;
    if (rq.op == OP_WAIT) begin
      ok = (rq.tid < THREADS) && (rq.cur == rq.expv);
      if (ok) begin
        old = q_waiting[rq.tid] ? q_rank[rq.tid] : THREADS;
        for (int u = 0; u < THREADS; u++)
          if (u != rq.tid && q_waiting[u] && q_rank[u] < old) q_rank[u]++;
        q_waiting[rq.tid] = 1'b1;
        q_addr[rq.tid] = rq.addr;
        q_rank[rq.tid] = 0;
      end
      expected_results.push_back(mk_res(ok, 1'b0, '0, '0, 1'b1));
    end else begin
      lim = (rq.maxw > THREADS) ? THREADS : rq.maxw;
      taken = 0;
      for (int k = 0; k < THREADS; k++) ordered[k] = -1;
      for (int t = 0; t < THREADS; t++)
        if (q_waiting[t] && q_rank[t] < THREADS) ordered[q_rank[t]] = t;
      for (int k = 0; k < THREADS && taken < lim; k++)
        if (ordered[k] >= 0 && q_addr[ordered[k]] == rq.addr) begin
          picked[taken] = ordered[k];
          taken++;
        end
      for (int k = 0; k < taken; k++) q_waiting[picked[k]] = 1'b0;
      for (int t = 0; t < THREADS; t++) begin
        r = 0;
        if (q_waiting[t])
          for (int u = 0; u < THREADS; u++)
            if (q_waiting[u] && q_rank[u] < q_rank[t]) r++;
        newrank[t] = r;
      end
      for (int t = 0; t < THREADS; t++) if (q_waiting[t]) q_rank[t] = newrank[t];
      nres = (taken < RESUME_LIMIT) ? taken : RESUME_LIMIT;
      if (nres == 0) expected_results.push_back(mk_res(1'b0, 1'b0, '0, 7'(taken), 1'b1));
      for (int k = 0; k < nres; k++)
        expected_results.push_back(mk_res(1'b0, 1'b1, 6'(picked[k]), 7'(taken),
                                          k == nres - 1));
    end
  endtask

  function automatic fx_req_t rand_req(input logic o, input logic [63:0] a);
    fx_req_t rq;
    rq.op = o;
    rq.addr = a;
    rq.tid = 6'($urandom_range(0, 63));
    rq.cur = $urandom;
    rq.expv = ($urandom_range(0, 9) < 8) ? rq.cur : $urandom;
    rq.maxw = 7'(($urandom_range(0, 5) == 0) ? $urandom_range(0, 127) :
                 $urandom_range(0, 20));
    return rq;
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Driver: one request is offered until accepted.
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (start && !busy) begin
      predict_queue({op, wait_address, thread_id, current_value, expected_value, max_wake});
      if (pending_reqs.size() > 0 && !hold_send && $urandom_range(0, 99) >= send_idle_pct)
        begin
        {op, wait_address, thread_id, current_value, expected_value, max_wake} <=
          pending_reqs.pop_front();
      end else begin
        start <= 1'b0;
      end
    end else if (!start && pending_reqs.size() > 0 && !hold_send &&
                 $urandom_range(0, 99) >= send_idle_pct) begin
      start <= 1'b1;
      {op, wait_address, thread_id, current_value, expected_value, max_wake} <=
        pending_reqs.pop_front();
    end
  end

  // Monitor and watchdog.
  always @(posedge clk) begin
    fx_res_t got, want;
    if (!rst) begin
      quiet_cycles <= (result_valid || (start && !busy)) ? 0 : quiet_cycles + 1;
      if (result_valid) begin
        got = mk_res(wait_accepted, woken_valid, woken_thread, woken_total, last);
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %p", got);
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch: expected %p actual %p", want, got);
          end
        end
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("tb_top: errors");
        $finish;
      end
    end
  end

  task automatic wait_drained();
    while (pending_reqs.size() > 0 || start || expected_results.size() > 0)
      @(posedge clk);
  endtask

  initial begin
    logic [63:0] addr_pool [4];
    fx_req_t rq;
    int grp;
    for (int t = 0; t < THREADS; t++) begin
      q_waiting[t] = 1'b0; q_addr[t] = '0; q_rank[t] = 0;
    end
    mismatches = 0; quiet_cycles = 0; hold_send = 1'b0;
    send_idle_pct = 31;
    rst = 1'b1; start = 1'b0; op = 1'b0; wait_address = '0; thread_id = '0;
    current_value = '0; expected_value = '0; max_wake = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed: wake on empty queue, extremes, mismatch, rewait, overflow.
    pending_reqs.push_back({OP_WAKE, 64'h0, 6'd0, 32'h0, 32'h0, 7'd64});
    pending_reqs.push_back({OP_WAIT, 64'hFFFF_FFFF_FFFF_FFFF, 6'd63, 32'hFFFF_FFFF,
                            32'hFFFF_FFFF, 7'd127});
    pending_reqs.push_back({OP_WAIT, 64'h0, 6'd0, 32'h0, 32'h1, 7'd0});
    pending_reqs.push_back({OP_WAIT, 64'h0, 6'd0, 32'h5, 32'h5, 7'd0});
    pending_reqs.push_back({OP_WAIT, 64'h0, 6'd63, 32'h7, 32'h7, 7'd0});
    pending_reqs.push_back({OP_WAIT, 64'h1, 6'd0, 32'h7, 32'h8, 7'd0});
    pending_reqs.push_back({OP_WAKE, 64'h0, 6'd0, 32'h0, 32'h0, 7'd0});
    pending_reqs.push_back({OP_WAKE, 64'h0, 6'd0, 32'h0, 32'h0, 7'd1});
    for (int t = 0; t < 20; t++)
      pending_reqs.push_back({OP_WAIT, 64'hA5A5, 6'(t), 32'h3, 32'h3, 7'd0});
    pending_reqs.push_back({OP_WAKE, 64'hA5A5, 6'd0, 32'h0, 32'h0, 7'd127});
    pending_reqs.push_back({OP_WAKE, 64'h0, 6'd0, 32'h0, 32'h0, 7'd64});
    pending_reqs.push_back({OP_WAKE, 64'hFFFF_FFFF_FFFF_FFFF, 6'd0, 32'h0, 32'h0, 7'd2});

    // Random: waits and wakes mixed, mostly on a pool of four addresses, in three phases.
    for (int phase = 0; phase < 3; phase++) begin
      wait_drained();
      if (phase == 1) begin
        hold_send = 1'b1;
        @(posedge clk);
        hold_send = 1'b0;
      end
      send_idle_pct = (phase == 0) ? 31 : (phase == 1) ? 87 : 0;
      for (int i = 0; i < 4; i++) addr_pool[i] = {$urandom, $urandom};
      grp = 0;
      while (grp < 146) begin
        rq = rand_req(($urandom_range(0, 3) == 0) ? OP_WAKE : OP_WAIT,
                      ($urandom_range(0, 9) == 0) ? {$urandom, $urandom} :
                      addr_pool[$urandom_range(0, 3)]);
        pending_reqs.push_back(rq);
        grp++;
      end
    end
    wait_drained();
    repeat (300) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end
endmodule

@@ futex_wait_queue.f @@
+incdir+rtl
rtl/fwq_pkg.sv
rtl/fwq_ram.sv
rtl/futex_wait_queue.sv
sim/tb_top.sv
